[rtl/sksa_pkg.sv]
// Shared types and constants for the seed/key security access engine.
package sksa_pkg;

  localparam logic [1:0] RESP_POSITIVE = 2'd0;
  localparam logic [1:0] RESP_DENIED   = 2'd1;
  localparam logic [1:0] RESP_INVALID  = 2'd2;

  localparam logic       OP_ACCESS     = 1'b0;
  localparam logic       OP_TABLE_WR   = 1'b1;

  localparam logic [7:0] SUB_MAX       = 8'h7F;
  localparam logic [8:0] ROUND_BIAS    = 9'h023;
  localparam logic [7:0] ROUND_MAX     = 8'hFF;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_NONCE = 5'b00010,
    S_POLY  = 5'b00100,
    S_RUN   = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lfsr_status_t;

endpackage

[rtl/sksa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sksa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sksa_lfsr.sv]
// Serial Galois LFSR unit, one round per cycle.
module sksa_lfsr (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           seed,
  input  logic [31:0]           poly,
  input  logic [7:0]            rounds,
  output sksa_pkg::lfsr_status_t status,
  output logic [31:0]           value
);

  logic [31:0] poly_q;
  logic [7:0]  count;
  logic        busy;
  logic        done;
  logic [31:0] step;

  assign step = {value[30:0], 1'b0} ^ (value[31] ? poly_q : 32'h0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 8'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= rounds;
      end else if (busy) begin
        count <= count - 8'd1;
        if (count == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value  <= seed;
      poly_q <= poly;
    end else if (busy) begin
      value <= step;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

[rtl/seed_key_security_access_top.sv]
// Top level of the seed/key security access engine.
//
//  channel | direction | handshake            | fields
//  in      | input     | in_valid / in_stall  | operation .. table_word
//  out     | output    | out_valid / out_stall| response_code, seed_out, access_level
//
//  Table writes, invalid and key items: result registered on the cycle after acceptance.
//  Seed request: 2 table reads, then min(session_value+35,255) LFSR rounds.
//  Reset clears the state, pending flag, granted level, rolling seed, expected key and output valid;
//  the table stays undefined. A stalled result blocks new items only while it waits in the output register.
module seed_key_security_access_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  subfunction,
  input  logic [7:0]  session_value,
  input  logic [31:0] key_in,
  input  logic [5:0]  timer_sel,
  input  logic [5:0]  table_index,
  input  logic [31:0] table_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  response_code,
  output logic [31:0] seed_out,
  output logic [7:0]  access_level
);

  localparam int AW = $clog2(TABLE_DEPTH);

  sksa_pkg::state_t       state;
  sksa_pkg::lfsr_status_t lfsr_stat;

  logic        key_pending;
  logic [7:0]  granted_level;
  logic [31:0] rolling_seed;
  logic [31:0] expected_key;
  logic [7:0]  session_q;
  logic [5:0]  level_idx;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [31:0]   lfsr_value;
  logic [8:0]    round_sum;
  logic [7:0]    rounds;
  logic          lfsr_start;
  logic [31:0]   diff;
  logic          key_match;
  logic          sub_valid;

  assign in_stall = (state != sksa_pkg::S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (operation == sksa_pkg::OP_TABLE_WR);
  assign ram_raddr = (state == sksa_pkg::S_IDLE) ? AW'(timer_sel) : AW'(level_idx);

  assign round_sum  = {1'b0, session_q} + sksa_pkg::ROUND_BIAS;
  assign rounds     = round_sum[8] ? sksa_pkg::ROUND_MAX : round_sum[7:0];
  assign lfsr_start = (state == sksa_pkg::S_POLY);

  assign diff      = key_in ^ expected_key;
  assign key_match = (diff[31:24] == diff[7:0]) && (diff[23:16] == diff[7:0]) &&
                     (diff[15:8] == diff[7:0]) && !diff[7];
  assign sub_valid = (subfunction != 8'd0) && (subfunction <= sksa_pkg::SUB_MAX);

  sksa_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(table_index)),
    .wdata (table_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sksa_lfsr u_lfsr (
    .clk    (clk),
    .rst    (rst),
    .start  (lfsr_start),
    .seed   (rolling_seed),
    .poly   (ram_rdata),
    .rounds (rounds),
    .status (lfsr_stat),
    .value  (lfsr_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sksa_pkg::S_IDLE;
      out_valid     <= 1'b0;
      key_pending   <= 1'b0;
      granted_level <= 8'd0;
      rolling_seed  <= 32'd0;
      expected_key  <= 32'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        sksa_pkg::S_IDLE: begin
          if (accept) begin
            session_q     <= session_value;
            level_idx     <= subfunction[6:1];
            seed_out      <= 32'd0;
            access_level  <= granted_level;
            response_code <= sksa_pkg::RESP_POSITIVE;
            if (operation == sksa_pkg::OP_TABLE_WR) begin
              out_valid <= 1'b1;
            end else if (!sub_valid) begin
              key_pending   <= 1'b0;
              response_code <= sksa_pkg::RESP_INVALID;
              out_valid     <= 1'b1;
            end else if (!subfunction[0]) begin
              out_valid <= 1'b1;
              if (!key_pending) begin
                response_code <= sksa_pkg::RESP_DENIED;
              end else begin
                key_pending <= 1'b0;
                if (key_match) begin
                  granted_level <= {1'b0, diff[6:0]} + 8'd1;
                  access_level  <= {1'b0, diff[6:0]} + 8'd1;
                end else begin
                  granted_level <= 8'd0;
                  access_level  <= 8'd0;
                  response_code <= sksa_pkg::RESP_DENIED;
                end
              end
            end else begin
              state <= sksa_pkg::S_NONCE;
            end
          end
        end
        sksa_pkg::S_NONCE: begin
          rolling_seed <= rolling_seed ^ ram_rdata;
          state        <= sksa_pkg::S_POLY;
        end
        sksa_pkg::S_POLY: begin
          state <= sksa_pkg::S_RUN;
        end
        sksa_pkg::S_RUN: begin
          if (lfsr_stat.done) begin
            expected_key  <= lfsr_value;
            key_pending   <= 1'b1;
            response_code <= sksa_pkg::RESP_POSITIVE;
            seed_out      <= rolling_seed;
            access_level  <= granted_level;
            out_valid     <= 1'b1;
            state         <= sksa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sksa_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_lfsr_in_run: assert property (@(posedge clk) disable iff (rst)
    lfsr_stat.busy |-> state == sksa_pkg::S_RUN)
    else $error("lfsr busy outside run state");

  a_ram_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == sksa_pkg::S_IDLE)
    else $error("table write outside idle");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || state == sksa_pkg::S_NONCE))
    else $error("accepted item made no progress");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    granted_level <= 8'd128)
    else $error("granted level out of range");

  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    (state == sksa_pkg::S_RUN && lfsr_stat.done) |=> key_pending && out_valid)
    else $error("seed request did not set pending key");

endmodule

[tb/tb.sv]
// Testbench for the seed/key security access engine: directed and random access traffic
// checked against an in-bench model of the engine.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic        op;
    logic [7:0]  sub;
    logic [7:0]  sess;
    logic [31:0] key;
    logic [5:0]  nonce;
    logic [5:0]  idx;
    logic [31:0] word;
  } access_item_t;

  typedef struct {
    logic [1:0]  code;
    logic [31:0] seed;
    logic [7:0]  level;
  } access_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [7:0]  subfunction = '0;
  logic [7:0]  session_value = '0;
  logic [31:0] key_in = '0;
  logic [5:0]  timer_sel = '0;
  logic [5:0]  table_index = '0;
  logic [31:0] table_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  response_code;
  logic [31:0] seed_out;
  logic [7:0]  access_level;

  logic        pending_model;
  logic [7:0]  level_model;
  logic [31:0] seed_model;
  logic [31:0] key_model;
  logic [31:0] poly_model [64];

  access_resp_t expected_responses [$];
  int err_count = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit steady = 1'b0;

  seed_key_security_access_top #(.TABLE_DEPTH(64)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .subfunction(subfunction),
    .session_value(session_value),
    .key_in(key_in),
    .timer_sel(timer_sel),
    .table_index(table_index),
    .table_word(table_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .response_code(response_code),
    .seed_out(seed_out),
    .access_level(access_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void predict_access(access_item_t it);
    access_resp_t r;
    logic [31:0] diff;
    logic [31:0] lfsr;
    logic [31:0] poly;
    int rounds;
    r.code = sksa_pkg::RESP_POSITIVE;
    r.seed = '0;
    if (it.op == sksa_pkg::OP_TABLE_WR) begin
      poly_model[it.idx] = it.word;
    end else if (it.sub == 8'd0 || it.sub > sksa_pkg::SUB_MAX) begin
      pending_model = 1'b0;
      r.code = sksa_pkg::RESP_INVALID;
    end else if (!it.sub[0]) begin
      if (!pending_model) begin
        r.code = sksa_pkg::RESP_DENIED;
      end else begin
        diff = it.key ^ key_model;
        pending_model = 1'b0;
        level_model = '0;
        if (diff == {4{diff[7:0]}} && !diff[7]) begin
          level_model = diff[7:0] + 8'd1;
        end else begin
          r.code = sksa_pkg::RESP_DENIED;
        end
      end
    end else begin
      poly = poly_model[it.sub[6:1]];
      rounds = int'(it.sess) + int'(sksa_pkg::ROUND_BIAS);
      if (rounds > int'(sksa_pkg::ROUND_MAX)) rounds = int'(sksa_pkg::ROUND_MAX);
      seed_model ^= poly_model[it.nonce];
      r.seed = seed_model;
      lfsr = seed_model;
      for (int i = 0; i < rounds; i++) begin
        lfsr = {lfsr[30:0], 1'b0} ^ (lfsr[31] ? poly : 32'd0);
      end
      key_model = lfsr;
      pending_model = 1'b1;
    end
    r.level = level_model;
    expected_responses.push_back(r);
  endfunction

  function automatic access_item_t random_item();
    access_item_t it;
    it.op = 1'($urandom_range(1));
    it.sub = 8'($urandom_range(255));
    it.sess = 8'($urandom_range(255));
    it.key = $urandom;
    it.nonce = 6'($urandom_range(63));
    it.idx = 6'($urandom_range(63));
    it.word = $urandom;
    return it;
  endfunction

  function automatic access_item_t table_item(logic [5:0] idx, logic [31:0] word);
    access_item_t it;
    it = random_item();
    it.op = sksa_pkg::OP_TABLE_WR;
    it.idx = idx;
    it.word = word;
    return it;
  endfunction

  function automatic access_item_t seed_item(logic [7:0] sub, logic [7:0] sess,
                                             logic [5:0] nonce);
    access_item_t it;
    it = random_item();
    it.op = sksa_pkg::OP_ACCESS;
    it.sub = sub;
    it.sess = sess;
    it.nonce = nonce;
    return it;
  endfunction

  function automatic access_item_t key_item(logic [7:0] sub, logic [31:0] key);
    access_item_t it;
    it = random_item();
    it.op = sksa_pkg::OP_ACCESS;
    it.sub = sub;
    it.key = key;
    return it;
  endfunction

  function automatic logic [31:0] level_key(logic [7:0] lvl_byte);
    return key_model ^ {4{lvl_byte}};
  endfunction

  task automatic send_item(access_item_t it);
    int gap;
    if (!steady && $urandom_range(99) < 19) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    subfunction <= it.sub;
    session_value <= it.sess;
    key_in <= it.key;
    timer_sel <= it.nonce;
    table_index <= it.idx;
    table_word <= it.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_access(it);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    wait (expected_responses.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    access_resp_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        $error("result with no expectation: code %0d seed %h level %0d",
               response_code, seed_out, access_level);
        err_count++;
      end else begin
        exp_r = expected_responses.pop_front();
        if (response_code !== exp_r.code) begin
          $error("response_code: expected %0d, actual %0d", exp_r.code, response_code);
          err_count++;
        end
        if (seed_out !== exp_r.seed) begin
          $error("seed_out: expected %h, actual %h", exp_r.seed, seed_out);
          err_count++;
        end
        if (access_level !== exp_r.level) begin
          $error("access_level: expected %0d, actual %0d", exp_r.level, access_level);
          err_count++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_req - 1;
      hold_req = 0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 19);
    end
  end

  task automatic test_table_load();
    for (int i = 0; i < 64; i++) begin
      send_item(table_item(6'(i), $urandom));
    end
  endtask

  task automatic test_directed();
    send_item(key_item(8'd2, 32'hFFFF_FFFF));
    send_item(key_item(8'd2, 32'h0000_0000));
    send_item(key_item(8'd0, $urandom));
    send_item(key_item(8'd128, $urandom));
    send_item(key_item(8'd255, $urandom));
    send_item(table_item(6'd2, 32'h0000_0000));
    send_item(table_item(6'd63, 32'hFFFF_FFFF));
    send_item(seed_item(8'd1, 8'd0, 6'd63));
    send_item(key_item(8'd2, level_key(8'h00)));
    send_item(seed_item(8'd127, 8'd255, 6'd0));
    send_item(key_item(8'd126, level_key(8'h7F)));
    send_item(seed_item(8'd5, 8'd220, 6'd1));
    send_item(key_item(8'd4, level_key(8'h80)));
    send_item(seed_item(8'd3, 8'd219, 6'd2));
    send_item(key_item(8'd6, key_model ^ 32'h0102_0304));
    send_item(seed_item(8'd7, 8'd10, 6'd3));
    send_item(key_item(8'd200, $urandom));
    send_item(key_item(8'd8, level_key(8'h03)));
    send_item(seed_item(8'd9, 8'd50, 6'd4));
    send_item(table_item(6'd9, $urandom));
    send_item(key_item(8'd10, level_key(8'h10)));
    send_item(seed_item(8'd11, 8'd1, 6'd5));
    send_item(seed_item(8'd13, 8'd2, 6'd6));
    send_item(key_item(8'd12, level_key(8'h22)));
    send_item(key_item(8'd2, level_key(8'h22)));
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_req = 800;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) begin
        send_item(seed_item(8'($urandom_range(0, 63) * 2 + 1), 8'd0,
                            6'($urandom_range(63))));
      end else begin
        send_item(table_item(6'($urandom_range(63)), $urandom));
      end
    end
    wait_for_results();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic(int n);
    int sent;
    int pick;
    logic [7:0] even_sub;
    sent = 0;
    while (sent < n) begin
      steady = (sent >= 600 && sent < 900);
      pick = $urandom_range(9);
      case (pick)
        0, 1: begin
          send_item(table_item(6'($urandom_range(63)), $urandom));
          sent++;
        end
        2: begin
          send_item(key_item($urandom_range(1) ? 8'd0 : 8'($urandom_range(128, 255)),
                             $urandom));
          sent++;
        end
        3: begin
          send_item(key_item(8'($urandom_range(1, 63) * 2), $urandom));
          sent++;
        end
        4: begin
          send_item(random_item());
          sent++;
        end
        default: begin
          send_item(seed_item(8'($urandom_range(0, 63) * 2 + 1), 8'($urandom_range(255)),
                              6'($urandom_range(63))));
          even_sub = 8'($urandom_range(1, 63) * 2);
          pick = $urandom_range(9);
          if (pick < 7) begin
            send_item(key_item(even_sub, level_key(8'($urandom_range(0, 127)))));
          end else if (pick == 7) begin
            send_item(key_item(even_sub, level_key(8'($urandom_range(128, 255)))));
          end else begin
            send_item(key_item(even_sub, $urandom));
          end
          sent += 2;
        end
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    pending_model = 1'b0;
    level_model = '0;
    seed_model = '0;
    key_model = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_backpressure();
    test_random_traffic(1800);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_responses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sksa_pkg.sv
rtl/sksa_ram.sv
rtl/sksa_lfsr.sv
rtl/seed_key_security_access_top.sv
tb/tb.sv
